### hdl/mfpc_pkg.sv
package mfpc_pkg;

	localparam int MAX_COLUMNS_DEF = 64;
	localparam int MAX_ROWS_DEF    = 4096;
	localparam int COST_WIDTH_DEF  = 32;

	localparam int FARE_W         = 16;
	localparam int ROW_COUNT_W    = 13;
	localparam int COLUMN_COUNT_W = 7;
	localparam int RESULT_W       = 32;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 13;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic has_left;
		logic has_right;
		logic job_end;
	} cell_flags_t;

	localparam int FLAG_W = $bits(cell_flags_t);

	typedef struct packed {
		logic [RESULT_W-1:0] min_cost;
		logic                saturated;
	} result_t;

endpackage

### hdl/min_falling_path_cost.sv
// Minimum falling path cost over a streamed grid.
// Set row_count (index 0) and column_count (index 1) through the cfg
// channel while the block is idle; cfg_ready is always high and any write
// to either register restarts the job. Zero counts act as one, counts above
// the line buffer depth or row limit act as that limit.
// Push the cell fares in row-major order on fare_value while full is low.
// One word is taken per cycle while full is low, with no gaps between rows
// or jobs: the line buffer RAM is written once, read at most once, per cell.
// After the last cell of a job one result word (min_cost, saturated) is
// queued; it passes the input queue, the s1 stage and the result queue,
// and is held on the result ports while empty is low until pop takes it.
// A four-word queue parts the input classifier from the cost datapath, and
// a two-word queue holds results. When the result queue is full and a job
// ends, the datapath halts, the input queue fills and full rises.
// Reset empties both queues, sets both counts to one and restarts the job;
// the line buffer is not cleared, as every entry in use is written by the
// first row of a job before its stored value is used.
module min_falling_path_cost #(
	parameter int MAX_COLUMNS = mfpc_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = mfpc_pkg::MAX_ROWS_DEF,
	parameter int COST_WIDTH  = mfpc_pkg::COST_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mfpc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [mfpc_pkg::FARE_W-1:0]      fare_value,
	output logic                             empty,
	input  logic                             pop,
	output logic [mfpc_pkg::RESULT_W-1:0]    min_cost,
	output logic                             saturated
);

	import mfpc_pkg::*;

	localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int COLW   = $clog2(MAX_COLUMNS + 1);
	localparam int ROWW   = $clog2(MAX_ROWS + 1);
	localparam int CELL_W = FARE_W + IDX_W + FLAG_W;

	logic [ROW_COUNT_W-1:0]    row_count_q;
	logic [COLUMN_COUNT_W-1:0] column_count_q;
	logic [COLW-1:0]           cols;
	logic [ROWW-1:0]           rows;
	logic                      restart;

	logic                      q_push;
	logic [CELL_W-1:0]         q_wr_data;
	logic                      q_full;
	logic                      q_pop;
	logic [CELL_W-1:0]         q_rd_data;
	logic                      q_empty;

	logic                      out_push;
	result_t                   out_data;
	logic                      out_full;
	result_t                   out_word;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && ((cfg_index == REG_ROW_COUNT) ||
		(cfg_index == REG_COLUMN_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_COUNT_W'(1);
			column_count_q <= COLUMN_COUNT_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_COUNT: begin
					row_count_q <= cfg_data[ROW_COUNT_W-1:0];
				end
				REG_COLUMN_COUNT: begin
					column_count_q <= cfg_data[COLUMN_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (column_count_q == '0) begin
			cols = COLW'(1);
		end else if (int'(column_count_q) > MAX_COLUMNS) begin
			cols = COLW'(MAX_COLUMNS);
		end else begin
			cols = COLW'(column_count_q);
		end
		if (row_count_q == '0) begin
			rows = ROWW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows = ROWW'(MAX_ROWS);
		end else begin
			rows = ROWW'(row_count_q);
		end
	end

	mfpc_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.cols      (cols),
		.rows      (rows),
		.push      (push),
		.fare_value(fare_value),
		.full      (full),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wr_data)
	);

	mfpc_fifo #(
		.WIDTH(CELL_W),
		.DEPTH(QUEUE_DEPTH)
	) u_cell_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr_data),
		.full   (q_full),
		.pop    (q_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	mfpc_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.COST_WIDTH (COST_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_pop   (q_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_data(out_data)
	);

	mfpc_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wr_data(out_data),
		.full   (out_full),
		.pop    (pop),
		.rd_data(out_word),
		.empty  (empty)
	);

	assign min_cost  = out_word.min_cost;
	assign saturated = out_word.saturated;

endmodule

### hdl/mfpc_ram.sv
module mfpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/mfpc_fifo.sv
module mfpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hdl/mfpc_front.sv
module mfpc_front #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 4096,
	localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int COLW   = $clog2(MAX_COLUMNS + 1),
	localparam int ROWW   = $clog2(MAX_ROWS + 1),
	localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CELL_W = mfpc_pkg::FARE_W + IDX_W + mfpc_pkg::FLAG_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [COLW-1:0]             cols,
	input  logic [ROWW-1:0]             rows,
	input  logic                        push,
	input  logic [mfpc_pkg::FARE_W-1:0] fare_value,
	output logic                        full,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [CELL_W-1:0]           q_data
);

	import mfpc_pkg::*;

	logic [IDX_W-1:0]  col_q;
	logic [RIDX_W-1:0] row_q;
	logic              last_col;
	logic              last_row;
	cell_flags_t       flags;

	assign last_col = (COLW'(col_q) == cols - COLW'(1));
	assign last_row = (ROWW'(row_q) == rows - ROWW'(1));

	always_comb begin
		flags.first_row = (row_q == '0);
		flags.last_row  = last_row;
		flags.has_left  = (col_q != '0);
		flags.has_right = !last_col;
		flags.job_end   = last_col && last_row;
	end

	assign full   = q_full;
	assign q_push = push && !q_full;
	assign q_data = {fare_value, col_q, flags};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RIDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

endmodule

### hdl/mfpc_back.sv
module mfpc_back #(
	parameter int MAX_COLUMNS = 64,
	parameter int COST_WIDTH  = 32,
	localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int CELL_W = mfpc_pkg::FARE_W + IDX_W + mfpc_pkg::FLAG_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic                   q_empty,
	input  logic [CELL_W-1:0]      q_data,
	output logic                   q_pop,
	input  logic                   out_full,
	output logic                   out_push,
	output mfpc_pkg::result_t      out_data
);

	import mfpc_pkg::*;

	logic [FARE_W-1:0]     head_fare;
	logic [IDX_W-1:0]      head_col;
	cell_flags_t           head_flags;
	logic [IDX_W-1:0]      rd_addr;
	logic [COST_WIDTH-1:0] ram_rd;

	logic                  v_s1;
	logic [FARE_W-1:0]     fare_s1;
	logic [IDX_W-1:0]      col_s1;
	cell_flags_t           flags_s1;
	logic                  fwd_s1;
	logic [COST_WIDTH-1:0] fwd_cost_s1;

	logic [COST_WIDTH-1:0] first_q;
	logic [COST_WIDTH-1:0] right_q;
	logic [COST_WIDTH-1:0] left_q;
	logic [COST_WIDTH-1:0] run_min_q;
	logic                  ovf_q;

	logic [COST_WIDTH-1:0] old_cost;
	logic [COST_WIDTH-1:0] right_cost;
	logic [COST_WIDTH-1:0] best;
	logic [COST_WIDTH:0]   sum;
	logic [COST_WIDTH-1:0] new_cost;
	logic                  ovf_now;
	logic [COST_WIDTH-1:0] last_min;
	logic                  stall;
	logic                  adv;
	logic                  done;

	assign head_fare  = q_data[CELL_W-1 -: FARE_W];
	assign head_col   = q_data[FLAG_W +: IDX_W];
	assign head_flags = cell_flags_t'(q_data[FLAG_W-1:0]);
	assign rd_addr    = head_col + IDX_W'(1);

	assign stall = v_s1 && flags_s1.job_end && out_full;
	assign adv   = !stall;
	assign q_pop = adv && !q_empty;
	assign done  = adv && v_s1;

	mfpc_ram #(
		.WIDTH(COST_WIDTH),
		.DEPTH(MAX_COLUMNS)
	) u_line_buf (
		.clk    (clk),
		.wr_en  (done),
		.wr_addr(col_s1),
		.wr_data(new_cost),
		.rd_en  (q_pop && head_flags.has_right),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	always_comb begin
		old_cost   = (col_s1 == '0) ? first_q : right_q;
		right_cost = fwd_s1 ? fwd_cost_s1 : ram_rd;
		best       = old_cost;
		if (flags_s1.has_left && (left_q < best)) begin
			best = left_q;
		end
		if (flags_s1.has_right && (right_cost < best)) begin
			best = right_cost;
		end
		sum = {1'b0, best} + (COST_WIDTH + 1)'(fare_s1);
		if (flags_s1.first_row) begin
			new_cost = COST_WIDTH'(fare_s1);
			ovf_now  = 1'b0;
		end else begin
			new_cost = sum[COST_WIDTH] ? '1 : sum[COST_WIDTH-1:0];
			ovf_now  = sum[COST_WIDTH];
		end
		last_min = (flags_s1.last_row && (new_cost < run_min_q)) ? new_cost : run_min_q;
	end

	assign out_push           = done && flags_s1.job_end;
	assign out_data.min_cost  = RESULT_W'(last_min);
	assign out_data.saturated = ovf_q || ovf_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			left_q    <= '0;
			run_min_q <= '1;
			ovf_q     <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= q_pop;
			end
			if (restart) begin
				left_q    <= '0;
				run_min_q <= '1;
				ovf_q     <= 1'b0;
			end else if (done) begin
				left_q <= old_cost;
				if (flags_s1.job_end) begin
					run_min_q <= '1;
					ovf_q     <= 1'b0;
				end else begin
					run_min_q <= last_min;
					ovf_q     <= ovf_q || ovf_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			fare_s1     <= head_fare;
			col_s1      <= head_col;
			flags_s1    <= head_flags;
			fwd_s1      <= v_s1 && (col_s1 == rd_addr);
			fwd_cost_s1 <= new_cost;
		end
		if (done) begin
			right_q <= right_cost;
			if (col_s1 == '0) begin
				first_q <= new_cost;
			end
		end
	end

endmodule

### hdl/mfpc_checker.sv
module mfpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic [mfpc_pkg::RESULT_W-1:0] min_cost,
	input logic                          saturated
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(min_cost) && $stable(saturated)))
		else $error("waiting result word changed");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted word");

	a_empty_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result queue drained without pop");

	a_reset_state: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("queues not empty out of reset");

endmodule

bind min_falling_path_cost mfpc_checker u_checker (.*);

### test/tb_min_falling_path_cost.sv
`timescale 1ns / 1ps

module tb_min_falling_path_cost;
	import mfpc_pkg::*;

	localparam int SETTLE_CYCLES = 16;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      push;
	logic                      full;
	logic [FARE_W-1:0]         fare_value;
	logic                      empty;
	logic                      pop;
	logic [RESULT_W-1:0]       min_cost;
	logic                      saturated;

	result_t                   expected_minima[$];
	int                        mismatch_count;
	int                        send_max_gap;
	int                        recv_max_gap;
	int                        result_hold_cycles;

	logic [ROW_COUNT_W-1:0]    cur_rows;
	logic [COLUMN_COUNT_W-1:0] cur_columns;
	logic [RESULT_W-1:0]       line_costs [MAX_COLUMNS_DEF];
	logic [RESULT_W-1:0]       left_above;
	logic [RESULT_W-1:0]       final_min;
	logic                      overflow_flag;
	int                        col_pos;
	int                        row_pos;

	min_falling_path_cost dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.fare_value (fare_value),
		.empty      (empty),
		.pop        (pop),
		.min_cost   (min_cost),
		.saturated  (saturated)
	);

	always #10 clk = ~clk;

	function automatic int effective_count(input int raw, input int top);
		if (raw == 0)
			return 1;
		if (raw > top)
			return top;
		return raw;
	endfunction

	function automatic logic [FARE_W-1:0] random_fare();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return FARE_W'($urandom_range(0, 15));
			default: return FARE_W'($urandom());
		endcase
	endfunction

	task automatic restart_path_job();
		left_above    = '0;
		col_pos       = 0;
		row_pos       = 0;
		final_min     = '1;
		overflow_flag = 1'b0;
	endtask

	task automatic update_path_cost(input logic [FARE_W-1:0] fare);
		int                  cols;
		int                  rows;
		int                  j;
		logic [RESULT_W-1:0] above;
		logic [RESULT_W-1:0] best;
		logic [RESULT_W-1:0] cost;
		logic [RESULT_W:0]   sum;
		result_t             res;
		cols = effective_count(cur_columns, MAX_COLUMNS_DEF);
		rows = effective_count(cur_rows, MAX_ROWS_DEF);
		j = col_pos;
		if (j >= cols)
			j = 0;
		if (row_pos >= rows)
			row_pos = 0;
		above = line_costs[j];
		if (row_pos == 0) begin
			cost = RESULT_W'(fare);
		end else begin
			best = above;
			if (j > 0 && left_above < best)
				best = left_above;
			if (j + 1 < cols && line_costs[j + 1] < best)
				best = line_costs[j + 1];
			sum = {1'b0, best} + (RESULT_W + 1)'(fare);
			if (sum[RESULT_W]) begin
				cost          = '1;
				overflow_flag = 1'b1;
			end else begin
				cost = sum[RESULT_W-1:0];
			end
		end
		line_costs[j] = cost;
		left_above    = above;
		if (row_pos == rows - 1 && cost < final_min)
			final_min = cost;
		j++;
		if (j < cols) begin
			col_pos = j;
		end else begin
			col_pos = 0;
			if (row_pos + 1 < rows) begin
				row_pos++;
			end else begin
				res.min_cost  = final_min;
				res.saturated = overflow_flag;
				expected_minima = {expected_minima, res};
				restart_path_job();
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ROW_COUNT)
			cur_rows = data[ROW_COUNT_W-1:0];
		else if (idx == REG_COLUMN_COUNT)
			cur_columns = data[COLUMN_COUNT_W-1:0];
		restart_path_job();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_grid(input int rows, input int cols);
		write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
		write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(cols));
	endtask

	task automatic send_fare(input logic [FARE_W-1:0] fare);
		int gap;
		gap = $urandom_range(0, send_max_gap);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push       = 1'b1;
		fare_value = fare;
		do @(posedge clk); while (full);
		update_path_cost(fare);
		@(negedge clk);
	endtask

	task automatic send_cells(input int n);
		repeat (n) send_fare(random_fare());
	endtask

	// drain, then let in-flight cells settle before touching the registers
	task automatic wait_idle();
		int n;
		n = 0;
		push = 1'b0;
		while (expected_minima.size() != 0 && n < 200000) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_result();
		result_t want;
		if (expected_minima.size() == 0) begin
			$display("%0t: unexpected result word min_cost %h saturated %b",
				$time, min_cost, saturated);
			mismatch_count++;
		end else begin
			want = expected_minima.pop_front();
			if (min_cost !== want.min_cost) begin
				$display("%0t: min_cost expected %h actual %h",
					$time, want.min_cost, min_cost);
				mismatch_count++;
			end
			if (saturated !== want.saturated) begin
				$display("%0t: saturated expected %b actual %b",
					$time, want.saturated, saturated);
				mismatch_count++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_fare('0);
		send_fare('1);
		send_fare(16'h5555);
		send_fare(16'hAAAA);
		wait_idle();
	endtask

	task automatic test_single_column();
		set_grid(0, 1);
		send_fare(16'h0001);
		wait_idle();
		set_grid(3, 1);
		repeat (3) send_fare('1);
		wait_idle();
	endtask

	task automatic test_edge_columns();
		logic [FARE_W-1:0] grid [9];
		grid = '{16'd5, 16'd1, 16'd9, 16'd2, 16'd7, 16'd3, 16'd1, 16'd1, 16'd1};
		set_grid(3, 3);
		foreach (grid[k])
			send_fare(grid[k]);
		wait_idle();
		set_grid(2, 2);
		send_fare(16'd9);
		send_fare(16'd0);
		send_fare(16'd0);
		send_fare('1);
		wait_idle();
	endtask

	task automatic test_restart_mid_job();
		set_grid(3, 4);
		send_cells(5);
		wait_idle();
		write_reg(REG_ROW_COUNT, CFG_DATA_W'(2));
		send_cells(8);
		wait_idle();
	endtask

	task automatic test_clamped_counts();
		set_grid(1, 127);
		send_cells(64);
		wait_idle();
		// upper data bits are dropped by the column register
		write_reg(REG_COLUMN_COUNT, 13'h1F85);
		send_cells(5);
		wait_idle();
	endtask

	task automatic test_largest_grid();
		set_grid(8191, 0);
		repeat (MAX_ROWS_DEF / 8) send_fare('1);
		wait_idle();
	endtask

	task automatic test_result_stall();
		set_grid(1, 1);
		send_max_gap       = 0;
		result_hold_cycles = 300;
		send_cells(40);
		wait_idle();
		send_max_gap = 9;
	endtask

	task automatic test_random_grids(input int target);
		int                     sent;
		int                     rows;
		int                     cols;
		int                     cells;
		int                     jobs;
		int                     extra;
		logic [CFG_DATA_W-1:0]  col_data;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 9) < 2) begin
				send_max_gap = 0;
				recv_max_gap = 0;
			end else begin
				send_max_gap = 9;
				recv_max_gap = 9;
			end
			case ($urandom_range(0, 19))
				0: cols = 0;
				1: cols = MAX_COLUMNS_DEF;
				2: cols = $urandom_range(65, 127);
				default: cols = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 19))
				0: rows = 0;
				1: rows = $urandom_range(9, 20);
				default: rows = $urandom_range(1, 8);
			endcase
			col_data = CFG_DATA_W'(cols);
			if ($urandom_range(0, 3) == 0)
				col_data[CFG_DATA_W-1:COLUMN_COUNT_W] =
					(CFG_DATA_W - COLUMN_COUNT_W)'($urandom());
			if ($urandom_range(0, 1)) begin
				write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
				write_reg(REG_COLUMN_COUNT, col_data);
			end else begin
				write_reg(REG_COLUMN_COUNT, col_data);
				write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
			end
			cells = effective_count(rows, MAX_ROWS_DEF)
				* effective_count(cols, MAX_COLUMNS_DEF);
			jobs = $urandom_range(1, 4);
			repeat (jobs) begin
				if (sent < target) begin
					send_cells(cells);
					sent += cells;
				end
			end
			// leave a job unfinished now and then
			if ($urandom_range(0, 9) == 0 && cells > 1) begin
				extra = $urandom_range(1, cells - 1);
				send_cells(extra);
				sent += extra;
			end
			wait_idle();
		end
		send_max_gap = 9;
		recv_max_gap = 9;
	endtask

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (result_hold_cycles > 0) begin
				pop = 1'b0;
				repeat (result_hold_cycles) @(negedge clk);
				result_hold_cycles = 0;
			end
			gap = $urandom_range(0, recv_max_gap);
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			check_result();
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_valid          = 1'b0;
		cfg_index          = REG_ROW_COUNT;
		cfg_data           = '0;
		push               = 1'b0;
		fare_value         = '0;
		mismatch_count     = 0;
		send_max_gap       = 9;
		recv_max_gap       = 9;
		result_hold_cycles = 0;
		cur_rows           = ROW_COUNT_W'(1);
		cur_columns        = COLUMN_COUNT_W'(1);
		foreach (line_costs[k])
			line_costs[k] = '0;
		restart_path_job();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_single_column();
		test_edge_columns();
		test_restart_mid_job();
		test_clamped_counts();
		test_result_stall();
		test_random_grids(1000);
		test_largest_grid();

		wait_idle();
		if (expected_minima.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, expected_minima.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/mfpc_pkg.sv
hdl/mfpc_ram.sv
hdl/mfpc_fifo.sv
hdl/mfpc_front.sv
hdl/mfpc_back.sv
hdl/min_falling_path_cost.sv
hdl/mfpc_checker.sv
test/tb_min_falling_path_cost.sv
